/* design/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the WebSocket frame deframer
// Parse phases, frame kinds, header bit masks and the result record that
// travels from the parser to the output buffer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Parse phases
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_DROP    = 2'd3
	} phase_t;

	// Frame kinds reported on each result
	localparam logic [2:0] KIND_COMPLETE  = 3'd0;
	localparam logic [2:0] KIND_FRAGMENT  = 3'd1;
	localparam logic [2:0] KIND_FINAL     = 3'd2;
	localparam logic [2:0] KIND_PING      = 3'd3;
	localparam logic [2:0] KIND_PONG      = 3'd4;
	localparam logic [2:0] KIND_CLOSE     = 3'd5;
	localparam logic [2:0] KIND_ERROR     = 3'd6;

	// Opcodes
	localparam logic [3:0] OP_LAST_DATA   = 4'h2;
	localparam logic [3:0] OP_CLOSE       = 4'h8;
	localparam logic [3:0] OP_PING        = 4'h9;
	localparam logic [3:0] OP_PONG        = 4'hA;

	// Header fields
	localparam logic [7:0] HDR_FIN_MASK   = 8'h80;
	localparam logic [7:0] HDR_RSV1_MASK  = 8'h40;
	localparam logic [7:0] HDR_OP_MASK    = 8'h0f;
	localparam logic [7:0] HDR_LEN_MASK   = 8'h7f;
	localparam logic [6:0] LEN_EXT16      = 7'd126;
	localparam logic [6:0] LEN_EXT64      = 7'd127;
	localparam logic [1:0] KEY_IDX_MASK   = 2'h3;
	localparam logic [15:0] NO_STATUS_CODE = 16'd1005;

	// One result item
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        data_valid;
		logic [2:0]  frame_kind;
		logic [3:0]  frame_opcode;
		logic        fin_bit;
		logic        compressed_bit;
		logic [63:0] payload_length;
		logic [15:0] close_code;
		logic        frame_end;
	} result_t;

	// Kind of the current frame from its opcode, fin and message state
	function automatic logic [2:0] kind_of(input logic [3:0] opcode, input logic fin,
		input logic frag_open);
		logic [2:0] k;
		if (opcode <= OP_LAST_DATA) begin
			if (!fin)
				k = KIND_FRAGMENT;
			else
				k = frag_open ? KIND_FINAL : KIND_COMPLETE;
		end else if (opcode == OP_CLOSE) begin
			k = KIND_CLOSE;
		end else if (opcode == OP_PING) begin
			k = KIND_PING;
		end else if (opcode == OP_PONG) begin
			k = KIND_PONG;
		end else begin
			k = KIND_ERROR;
		end
		return k;
	endfunction

	// Number of extended length bytes selected by the 7-bit length
	function automatic logic [3:0] ext_bytes(input logic [6:0] short_len);
		logic [3:0] n;
		if (short_len == LEN_EXT16)
			n = 4'd2;
		else if (short_len == LEN_EXT64)
			n = 4'd8;
		else
			n = 4'd0;
		return n;
	endfunction

endpackage

/* design/wsd_parse.sv */
// ----------------------------------------------------------------------------
// wsd_parse: frame header parser and payload unmasker
// Updates the parse state on every accepted byte and forms the result that
// the byte causes, if any, in the same cycle.
// ----------------------------------------------------------------------------
module wsd_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	output logic             res_push,
	output wsd_pkg::result_t res
);

	wsd_pkg::phase_t phase_q, phase_next;
	logic [3:0]  hdr_idx_q, hdr_idx_next;
	logic        fin_q, fin_next;
	logic        rsv1_q, rsv1_next;
	logic [3:0]  opcode_q, opcode_next;
	logic        mask_q, mask_next;
	logic [6:0]  short_len_q, short_len_next;
	logic [63:0] length_q, length_next;
	logic [31:0] key_q, key_next;
	logic [63:0] left_q, left_next;
	logic [1:0]  key_idx_q, key_idx_next;
	logic        frag_open_q, frag_open_next;
	logic [15:0] code_acc_q, code_acc_next;
	logic [1:0]  pos_q, pos_next;

	// Header byte decode
	logic        hdr_first;
	logic        hdr_mask;
	logic [6:0]  hdr_short;
	logic [3:0]  hdr_ext;
	logic [3:0]  hdr_total;
	logic [3:0]  hdr_idx_inc;
	logic [63:0] hdr_length;
	logic [31:0] hdr_key;
	logic        hdr_done;
	logic [2:0]  kind;
	logic        frag_after;

	// Payload byte decode
	logic [7:0]  key_byte;
	logic [7:0]  data;
	logic [15:0] acc_new;
	logic        pay_end;
	logic        left_le1;

	assign hdr_first = (hdr_idx_q <= 4'd1);
	assign hdr_mask  = hdr_first ? rx_byte[7] : mask_q;
	assign hdr_short = hdr_first ? (rx_byte[6:0] & wsd_pkg::HDR_LEN_MASK[6:0]) : short_len_q;
	assign hdr_ext   = wsd_pkg::ext_bytes(hdr_short);
	assign hdr_total = 4'd2 + hdr_ext + (hdr_mask ? 4'd4 : 4'd0);
	assign hdr_idx_inc = hdr_first ? 4'd2 : hdr_idx_q + 4'd1;
	assign hdr_done  = (hdr_idx_inc >= hdr_total);

	// Shift extended length bytes first, then key bytes
	always_comb begin
		hdr_length = length_q;
		hdr_key    = key_q;
		if (hdr_first) begin
			hdr_length = (hdr_short < wsd_pkg::LEN_EXT16) ? {57'd0, hdr_short} : 64'd0;
			hdr_key    = 32'd0;
		end else if (hdr_idx_q < 4'd2 + hdr_ext) begin
			hdr_length = {length_q[55:0], rx_byte};
		end else begin
			hdr_key = {key_q[23:0], rx_byte};
		end
	end

	assign kind       = wsd_pkg::kind_of(opcode_q, fin_q, frag_open_q);
	assign frag_after = (opcode_q <= wsd_pkg::OP_LAST_DATA) ? !fin_q : frag_open_q;

	// Unmask with key byte (index mod 4), most significant byte first
	always_comb begin
		unique case (key_idx_q & wsd_pkg::KEY_IDX_MASK)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end
	assign data = rx_byte ^ (mask_q ? key_byte : 8'd0);

	// Collect the close code from the first two payload bytes
	always_comb begin
		unique case (pos_q)
			2'd0:    acc_new = {data, 8'd0};
			2'd1:    acc_new = {code_acc_q[15:8], data};
			default: acc_new = code_acc_q;
		endcase
	end
	assign pay_end  = (left_q == 64'd1);
	assign left_le1 = (left_q <= 64'd1);

	// Next state
	always_comb begin
		phase_next     = phase_q;
		hdr_idx_next   = hdr_idx_q;
		fin_next       = fin_q;
		rsv1_next      = rsv1_q;
		opcode_next    = opcode_q;
		mask_next      = mask_q;
		short_len_next = short_len_q;
		length_next    = length_q;
		key_next       = key_q;
		left_next      = left_q;
		key_idx_next   = key_idx_q;
		frag_open_next = frag_open_q;
		code_acc_next  = code_acc_q;
		pos_next       = pos_q;
		if (step) begin
			unique case (phase_q)
				wsd_pkg::PH_IDLE: begin
					fin_next     = |(rx_byte & wsd_pkg::HDR_FIN_MASK);
					rsv1_next    = |(rx_byte & wsd_pkg::HDR_RSV1_MASK);
					opcode_next  = 4'(rx_byte & wsd_pkg::HDR_OP_MASK);
					hdr_idx_next = 4'd1;
					phase_next   = wsd_pkg::PH_HEADER;
				end
				wsd_pkg::PH_HEADER: begin
					mask_next      = hdr_mask;
					short_len_next = hdr_short;
					length_next    = hdr_length;
					key_next       = hdr_key;
					hdr_idx_next   = hdr_idx_inc;
					if (hdr_done) begin
						hdr_idx_next  = 4'd0;
						left_next     = hdr_length;
						key_idx_next  = 2'd0;
						code_acc_next = 16'd0;
						pos_next      = 2'd0;
						if (kind == wsd_pkg::KIND_ERROR) begin
							phase_next = (hdr_length != 64'd0) ? wsd_pkg::PH_DROP
								: wsd_pkg::PH_IDLE;
						end else if (hdr_length == 64'd0) begin
							frag_open_next = frag_after;
							phase_next     = wsd_pkg::PH_IDLE;
						end else begin
							phase_next = wsd_pkg::PH_PAYLOAD;
						end
					end
				end
				wsd_pkg::PH_PAYLOAD: begin
					code_acc_next = acc_new;
					key_idx_next  = key_idx_q + 2'd1;
					left_next     = left_q - 64'd1;
					pos_next      = (pos_q == 2'd2) ? pos_q : pos_q + 2'd1;
					if (pay_end) begin
						frag_open_next = frag_after;
						phase_next     = wsd_pkg::PH_IDLE;
					end
				end
				default: begin
					// Drop payload of an unknown-opcode frame
					if (left_q != 64'd0)
						left_next = left_q - 64'd1;
					if (left_le1)
						phase_next = wsd_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// Result of this byte
	always_comb begin
		res_push           = 1'b0;
		res.payload_byte   = 8'd0;
		res.data_valid     = 1'b0;
		res.frame_kind     = kind;
		res.frame_opcode   = opcode_q;
		res.fin_bit        = fin_q;
		res.compressed_bit = rsv1_q;
		res.payload_length = length_q;
		res.close_code     = 16'd0;
		res.frame_end      = 1'b0;
		unique case (phase_q)
			wsd_pkg::PH_HEADER: begin
				res.payload_length = hdr_length;
				res.frame_end      = 1'b1;
				if (kind == wsd_pkg::KIND_CLOSE)
					res.close_code = wsd_pkg::NO_STATUS_CODE;
				res_push = step && hdr_done
					&& ((kind == wsd_pkg::KIND_ERROR) || (hdr_length == 64'd0));
			end
			wsd_pkg::PH_PAYLOAD: begin
				res.payload_byte = data;
				res.data_valid   = 1'b1;
				res.frame_end    = pay_end;
				if (pay_end && kind == wsd_pkg::KIND_CLOSE)
					res.close_code = (length_q >= 64'd2) ? acc_new : wsd_pkg::NO_STATUS_CODE;
				res_push = step;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wsd_pkg::PH_IDLE;
			hdr_idx_q   <= 4'd0;
			fin_q       <= 1'b0;
			rsv1_q      <= 1'b0;
			opcode_q    <= 4'd0;
			mask_q      <= 1'b0;
			short_len_q <= 7'd0;
			length_q    <= 64'd0;
			key_q       <= 32'd0;
			left_q      <= 64'd0;
			key_idx_q   <= 2'd0;
			frag_open_q <= 1'b0;
			code_acc_q  <= 16'd0;
			pos_q       <= 2'd0;
		end else begin
			phase_q     <= phase_next;
			hdr_idx_q   <= hdr_idx_next;
			fin_q       <= fin_next;
			rsv1_q      <= rsv1_next;
			opcode_q    <= opcode_next;
			mask_q      <= mask_next;
			short_len_q <= short_len_next;
			length_q    <= length_next;
			key_q       <= key_next;
			left_q      <= left_next;
			key_idx_q   <= key_idx_next;
			frag_open_q <= frag_open_next;
			code_acc_q  <= code_acc_next;
			pos_q       <= pos_next;
		end
	end

	// A payload phase always has bytes still to come
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsd_pkg::PH_PAYLOAD) |-> (left_q != 64'd0))
		else $error("payload phase with no bytes left");

	// Header index stays within the longest header
	a_hdr_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsd_pkg::PH_HEADER) |-> (hdr_idx_q >= 4'd1 && hdr_idx_q <= 4'd13))
		else $error("header index out of range");

	// Idle phase starts with a cleared header index
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsd_pkg::PH_IDLE) |-> (hdr_idx_q == 4'd0))
		else $error("idle phase with header index set");

endmodule

/* design/wsd_out_buf.sv */
// ----------------------------------------------------------------------------
// wsd_out_buf: result register with skid stage
// Holds up to two results so the parser can still hand over a result while
// the consumer stalls.
// ----------------------------------------------------------------------------
module wsd_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wsd_pkg::result_t push_res,
	output logic             can_take,
	output logic             out_valid,
	input  logic             out_ready,
	output wsd_pkg::result_t out_res
);

	logic             out_valid_q;
	logic             skid_valid_q;
	wsd_pkg::result_t out_q;
	wsd_pkg::result_t skid_q;
	logic             pop;
	logic             load_out;

	assign pop      = out_valid_q && out_ready;
	assign load_out = !out_valid_q || pop;
	assign can_take = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move payloads: skid drains first, a new request fills the free slot
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	// Skid holds data only behind a waiting result
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid full with empty output register");

	// A stalled result with a new request fills the skid
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && push) |=> skid_valid_q)
		else $error("request lost while output stalled");

endmodule

/* design/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer: WebSocket frame parser and payload unmasker
// Parses the frame header byte by byte and emits one unmasked result per
// payload byte, one marker for an empty frame and one for an unknown opcode.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+----------------------------------
//   byte in  | byte_valid / byte_ready      | rx_byte
//   result   | result_valid / result_ready  | payload_byte .. frame_end
//
// One byte is taken per cycle while byte_ready is high; its result, if any,
// is registered in the output register, or in the skid while that stalls.
// The parser state updates in the cycle the byte is accepted. A two-entry
// output buffer (register plus skid) decouples the sides: byte_ready drops
// only while both entries hold results. Reset clears the parser to wait for
// a first header byte with no fragmented message open.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  payload_byte,
	output logic        data_valid,
	output logic [2:0]  frame_kind,
	output logic [3:0]  frame_opcode,
	output logic        fin_bit,
	output logic        compressed_bit,
	output logic [63:0] payload_length,
	output logic [15:0] close_code,
	output logic        frame_end
);

	logic             step;
	logic             res_push;
	wsd_pkg::result_t res;
	wsd_pkg::result_t out_res;

	assign step = byte_valid && byte_ready;

	wsd_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (rx_byte),
		.res_push (res_push),
		.res      (res)
	);

	wsd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_res  (res),
		.can_take  (byte_ready),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_res   (out_res)
	);

	// Unpack the result record
	assign payload_byte   = out_res.payload_byte;
	assign data_valid     = out_res.data_valid;
	assign frame_kind     = out_res.frame_kind;
	assign frame_opcode   = out_res.frame_opcode;
	assign fin_bit        = out_res.fin_bit;
	assign compressed_bit = out_res.compressed_bit;
	assign payload_length = out_res.payload_length;
	assign close_code     = out_res.close_code;
	assign frame_end      = out_res.frame_end;

endmodule

/* test/websocket_frame_deframer_tb.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb: self-checking bench for the frame deframer
// Feeds WebSocket frames one byte per request. A few hand-picked frames come
// first, then random messages, control frames and malformed frames. Each
// accepted byte runs through a bit-exact parser model in the scoreboard, and
// each accepted result is compared field by field with the oldest prediction.
// Both sides insert random gaps; once the result side holds off for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

	// Data opcodes not named in the package
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;

	// Extended length modes of a generated header
	localparam int unsigned LEN_SHORT = 0;
	localparam int unsigned LEN_16    = 1;
	localparam int unsigned LEN_64    = 2;

	localparam int unsigned RANDOM_BYTES = 820;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned LIMIT_CYCLES = 600000;

	// Parser model plus the queue of results it predicts
	class frame_checker;
		wsd_pkg::phase_t phase = wsd_pkg::PH_IDLE;
		logic [3:0]  hdr_idx = '0;
		logic        fin = 1'b0;
		logic        rsv1 = 1'b0;
		logic [3:0]  op = '0;
		logic        masked = 1'b0;
		logic [6:0]  len7 = '0;
		logic [63:0] len = '0;
		logic [31:0] key = '0;
		logic [63:0] left = '0;
		logic [1:0]  kidx = '0;
		logic        msg_open = 1'b0;
		logic [15:0] code_acc = '0;

		wsd_pkg::result_t pending_results[$];
		int unsigned errors = 0;
		int unsigned checked = 0;
		int unsigned kinds_seen[8];

		function int unsigned ext_count();
			case (len7)
				wsd_pkg::LEN_EXT16: return 2;
				wsd_pkg::LEN_EXT64: return 8;
				default:            return 0;
			endcase
		endfunction

		function logic [2:0] kind_now();
			case (op)
				OP_CONT, OP_TEXT, OP_BINARY: begin
					if (!fin)
						return wsd_pkg::KIND_FRAGMENT;
					return msg_open ? wsd_pkg::KIND_FINAL : wsd_pkg::KIND_COMPLETE;
				end
				wsd_pkg::OP_CLOSE: return wsd_pkg::KIND_CLOSE;
				wsd_pkg::OP_PING:  return wsd_pkg::KIND_PING;
				wsd_pkg::OP_PONG:  return wsd_pkg::KIND_PONG;
				default:           return wsd_pkg::KIND_ERROR;
			endcase
		endfunction

		// Update message state at the end of a data frame
		function void close_frame();
			if (op <= OP_BINARY)
				msg_open = !fin;
		endfunction

		function void push_result(logic [7:0] data, logic valid, logic [2:0] kind,
			logic [15:0] code, logic last);
			wsd_pkg::result_t r;
			r.payload_byte   = data;
			r.data_valid     = valid;
			r.frame_kind     = kind;
			r.frame_opcode   = op;
			r.fin_bit        = fin;
			r.compressed_bit = rsv1;
			r.payload_length = len;
			r.close_code     = code;
			r.frame_end      = last;
			pending_results.push_back(r);
		endfunction

		// Advance the model by one accepted byte
		function void take_byte(logic [7:0] b);
			logic [7:0]  data;
			logic [7:0]  kb;
			logic [63:0] pos;
			logic [2:0]  k;
			logic        last;
			logic [15:0] code;
			int unsigned ext;
			case (phase)
				wsd_pkg::PH_IDLE: begin
					fin     = b[7];
					rsv1    = b[6];
					op      = b[3:0];
					hdr_idx = 4'd1;
					phase   = wsd_pkg::PH_HEADER;
				end
				wsd_pkg::PH_HEADER: begin
					if (hdr_idx <= 1) begin
						masked  = b[7];
						len7    = b[6:0];
						len     = (len7 < wsd_pkg::LEN_EXT16) ? {57'd0, len7} : 64'd0;
						key     = '0;
						hdr_idx = 4'd2;
					end else begin
						if (hdr_idx < 2 + ext_count())
							len = {len[55:0], b};
						else
							key = {key[23:0], b};
						hdr_idx = hdr_idx + 4'd1;
					end
					ext = ext_count();
					if (hdr_idx >= 2 + ext + (masked ? 4 : 0)) begin
						hdr_idx  = '0;
						left     = len;
						kidx     = '0;
						code_acc = '0;
						k = kind_now();
						if (k == wsd_pkg::KIND_ERROR) begin
							phase = (len != 0) ? wsd_pkg::PH_DROP : wsd_pkg::PH_IDLE;
							push_result(8'd0, 1'b0, wsd_pkg::KIND_ERROR, 16'd0, 1'b1);
						end else if (len == 0) begin
							push_result(8'd0, 1'b0, k,
								(k == wsd_pkg::KIND_CLOSE) ? wsd_pkg::NO_STATUS_CODE
								: 16'd0, 1'b1);
							close_frame();
							phase = wsd_pkg::PH_IDLE;
						end else begin
							phase = wsd_pkg::PH_PAYLOAD;
						end
					end
				end
				wsd_pkg::PH_PAYLOAD: begin
					pos  = len - left;
					kb   = masked ? key[8 * (3 - kidx) +: 8] : 8'd0;
					data = b ^ kb;
					k    = kind_now();
					if (pos == 0)
						code_acc = {data, 8'd0};
					else if (pos == 1)
						code_acc[7:0] = data;
					kidx = kidx + 2'd1;
					left = left - 64'd1;
					last = (left == 0);
					code = 16'd0;
					if (last && k == wsd_pkg::KIND_CLOSE)
						code = (len >= 2) ? code_acc : wsd_pkg::NO_STATUS_CODE;
					push_result(data, 1'b1, k, code, last);
					if (last) begin
						close_frame();
						phase = wsd_pkg::PH_IDLE;
					end
				end
				default: begin
					if (left != 0)
						left = left - 64'd1;
					if (left == 0)
						phase = wsd_pkg::PH_IDLE;
				end
			endcase
		endfunction

		function void cmp(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(wsd_pkg::result_t got);
			wsd_pkg::result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result %h with none expected", $time, got);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			kinds_seen[want.frame_kind]++;
			cmp("payload_byte", want.payload_byte, got.payload_byte);
			cmp("data_valid", want.data_valid, got.data_valid);
			cmp("frame_kind", want.frame_kind, got.frame_kind);
			cmp("frame_opcode", want.frame_opcode, got.frame_opcode);
			cmp("fin_bit", want.fin_bit, got.fin_bit);
			cmp("compressed_bit", want.compressed_bit, got.compressed_bit);
			cmp("payload_length", want.payload_length, got.payload_length);
			cmp("close_code", want.close_code, got.close_code);
			cmp("frame_end", want.frame_end, got.frame_end);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_ready;
	logic [7:0]  rx_byte;
	logic        result_valid;
	logic        result_ready;
	logic [7:0]  payload_byte;
	logic        data_valid;
	logic [2:0]  frame_kind;
	logic [3:0]  frame_opcode;
	logic        fin_bit;
	logic        compressed_bit;
	logic [63:0] payload_length;
	logic [15:0] close_code;
	logic        frame_end;

	frame_checker chk = new();
	bit           gaps_on = 1'b1;
	bit           hold_req = 1'b0;
	int unsigned  bytes_sent = 0;
	int unsigned  frames_sent = 0;

	websocket_frame_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.payload_byte(payload_byte),
		.data_valid(data_valid),
		.frame_kind(frame_kind),
		.frame_opcode(frame_opcode),
		.fin_bit(fin_bit),
		.compressed_bit(compressed_bit),
		.payload_length(payload_length),
		.close_code(close_code),
		.frame_end(frame_end)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop
	initial begin
		#(20 * LIMIT_CYCLES);
		$display("websocket_frame_deframer_tb: done, errors");
		$finish;
	end

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one byte request and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		bit          took;
		gap = pick_gap();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte    <= b;
		do begin
			@(negedge clk);
			took = byte_ready;
			@(posedge clk);
		end while (!took);
		chk.take_byte(b);
		bytes_sent++;
	endtask

	// Build and send one frame; count may be below len for a frame cut short
	task automatic send_frame(input logic fin, input logic rsv1, input logic [3:0] op,
		input logic masked, input int unsigned ext_mode, input logic [63:0] len,
		input int unsigned count);
		logic [31:0] key;
		logic [7:0]  d;
		logic [7:0]  kb;
		logic [6:0]  len7;
		key = $urandom;
		case (ext_mode)
			LEN_16:  len7 = wsd_pkg::LEN_EXT16;
			LEN_64:  len7 = wsd_pkg::LEN_EXT64;
			default: len7 = len[6:0];
		endcase
		send_byte({fin, rsv1, 2'($urandom_range(0, 3)), op});
		send_byte({masked, len7});
		if (ext_mode == LEN_16) begin
			for (int i = 1; i >= 0; i--)
				send_byte(len[8 * i +: 8]);
		end else if (ext_mode == LEN_64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len[8 * i +: 8]);
		end
		if (masked) begin
			for (int i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		end
		for (int i = 0; i < count; i++) begin
			d  = 8'($urandom_range(0, 255));
			kb = masked ? key[8 * (3 - (i % 4)) +: 8] : 8'd0;
			send_byte(d ^ kb);
		end
		frames_sent++;
	endtask

	// Pick a length: mostly short, sometimes long or extended
	task automatic pick_len(output int unsigned ext_mode, output logic [63:0] len);
		int unsigned r;
		r = $urandom_range(0, 99);
		ext_mode = LEN_SHORT;
		if (r < 75) begin
			len = 64'($urandom_range(0, 12));
		end else if (r < 85) begin
			len = 64'($urandom_range(13, 125));
		end else if (r < 93) begin
			ext_mode = LEN_16;
			len = 64'($urandom_range(0, 200));
		end else begin
			ext_mode = LEN_64;
			len = 64'($urandom_range(0, 40));
		end
	endtask

	function automatic logic [3:0] odd_opcode();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return wsd_pkg::OP_LAST_DATA + 4'd1 + 4'(r);
		return wsd_pkg::OP_PONG + 4'd1 + 4'(r - 5);
	endfunction

	function automatic logic [3:0] control_opcode();
		case ($urandom_range(0, 2))
			0:       return wsd_pkg::OP_CLOSE;
			1:       return wsd_pkg::OP_PING;
			default: return wsd_pkg::OP_PONG;
		endcase
	endfunction

	task automatic random_frame(input logic fin, input logic [3:0] op);
		int unsigned ext_mode;
		logic [63:0] len;
		pick_len(ext_mode, len);
		send_frame(fin, 1'($urandom_range(0, 1)), op, $urandom_range(0, 99) < 85,
			ext_mode, len, 32'(len));
	endtask

	task automatic short_control();
		int unsigned n;
		n = $urandom_range(0, 4);
		send_frame($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), control_opcode(),
			$urandom_range(0, 99) < 85, LEN_SHORT, 64'(n), n);
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin
		wsd_pkg::result_t got;
		int unsigned stall_left;
		int unsigned hold_left;
		bit          hold_taken;
		stall_left = 0;
		hold_left  = 0;
		hold_taken = 1'b0;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_left  = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				stall_left = pick_gap();
			end
			@(negedge clk);
			if (result_valid && result_ready) begin
				got.payload_byte   = payload_byte;
				got.data_valid     = data_valid;
				got.frame_kind     = frame_kind;
				got.frame_opcode   = frame_opcode;
				got.fin_bit        = fin_bit;
				got.compressed_bit = compressed_bit;
				got.payload_length = payload_length;
				got.close_code     = close_code;
				got.frame_end      = frame_end;
				chk.check_result(got);
			end
		end
	end

	// Byte side: reset, directed frames, random traffic, drain
	initial begin
		int unsigned rand_start;
		int unsigned r;
		int unsigned n;
		int unsigned drain;
		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		rx_byte    <= 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Empty frame, masked payload with key wrap, compressed flag
		send_frame(1'b1, 1'b0, OP_TEXT, 1'b0, LEN_SHORT, 0, 0);
		send_frame(1'b1, 1'b1, OP_BINARY, 1'b1, LEN_SHORT, 5, 5);
		// Fragmented message with a ping inside, a new data opcode, final piece
		send_frame(1'b0, 1'b0, OP_TEXT, 1'b1, LEN_SHORT, 2, 2);
		send_frame(1'b1, 1'b0, wsd_pkg::OP_PING, 1'b1, LEN_SHORT, 0, 0);
		send_frame(1'b0, 1'b0, OP_CONT, 1'b0, LEN_SHORT, 1, 1);
		send_frame(1'b0, 1'b0, OP_BINARY, 1'b1, LEN_SHORT, 1, 1);
		send_frame(1'b1, 1'b0, OP_CONT, 1'b1, LEN_SHORT, 3, 3);
		// Continuation with no message open
		send_frame(1'b1, 1'b0, OP_CONT, 1'b0, LEN_SHORT, 1, 1);
		// Close with no code, with a cut code, with a full code
		send_frame(1'b1, 1'b0, wsd_pkg::OP_CLOSE, 1'b0, LEN_SHORT, 0, 0);
		send_frame(1'b1, 1'b0, wsd_pkg::OP_CLOSE, 1'b1, LEN_SHORT, 1, 1);
		send_frame(1'b1, 1'b0, wsd_pkg::OP_CLOSE, 1'b1, LEN_SHORT, 2, 2);
		// Fragmented pong
		send_frame(1'b0, 1'b0, wsd_pkg::OP_PONG, 1'b1, LEN_SHORT, 3, 3);
		// Unknown opcodes: empty, dropped payload, all header bits set
		send_frame(1'b1, 1'b0, wsd_pkg::OP_LAST_DATA + 4'd1, 1'b0, LEN_SHORT, 0, 0);
		send_frame(1'b1, 1'b0, wsd_pkg::OP_PONG + 4'd1, 1'b1, LEN_16, 2, 2);
		send_byte(8'hFF);
		send_byte(8'hFF);
		for (int i = 0; i < 7; i++)
			send_byte(8'h00);
		send_byte(8'h03);
		for (int i = 0; i < 7; i++)
			send_byte(8'($urandom_range(0, 255)));
		frames_sent++;
		// Extended lengths and the longest short length
		send_frame(1'b1, 1'b0, OP_TEXT, 1'b1, LEN_16, 0, 0);
		send_frame(1'b1, 1'b0, OP_BINARY, 1'b0, LEN_64, 3, 3);
		send_frame(1'b1, 1'b0, OP_TEXT, 1'b1, LEN_SHORT, 125, 125);
		send_frame(1'b1, 1'b1, OP_BINARY, 1'b1, LEN_16, 126, 126);

		// Random traffic; hold the result side off early so the block fills
		hold_req = 1'b1;
		rand_start = bytes_sent;
		while (bytes_sent - rand_start < RANDOM_BYTES) begin
			if ($urandom_range(0, 29) == 0)
				gaps_on = !gaps_on;
			r = $urandom_range(0, 99);
			if (r < 40) begin
				random_frame(1'b1, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY);
			end else if (r < 65) begin
				n = $urandom_range(2, 4);
				random_frame(1'b0, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY);
				for (int i = 1; i < n; i++) begin
					if ($urandom_range(0, 99) < 30)
						short_control();
					random_frame(i == n - 1, OP_CONT);
				end
			end else if (r < 82) begin
				if ($urandom_range(0, 4) == 0)
					random_frame(1'($urandom_range(0, 1)), control_opcode());
				else
					short_control();
			end else begin
				case ($urandom_range(0, 2))
					0:       random_frame(1'($urandom_range(0, 1)), odd_opcode());
					1:       random_frame(1'b1, OP_CONT);
					default: random_frame(1'($urandom_range(0, 1)),
						4'($urandom_range(0, 2)));
				endcase
			end
		end

		// Longest possible length, left unfinished at the end of the run
		send_frame(1'b1, 1'b0, OP_BINARY, 1'b1, LEN_64, 64'hFFFF_FFFF_FFFF_FFFF, 20);
		byte_valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		drain = 0;
		while (chk.pending_results.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (chk.pending_results.size() != 0) begin
			chk.errors += chk.pending_results.size();
			$display("%0t: %0d expected results never arrived", $time,
				chk.pending_results.size());
		end

		$display("covered %0d frames, %0d bytes in, %0d results checked", frames_sent,
			bytes_sent, chk.checked);
		$display("kinds: complete %0d fragment %0d final %0d ping %0d pong %0d close %0d error %0d",
			chk.kinds_seen[wsd_pkg::KIND_COMPLETE], chk.kinds_seen[wsd_pkg::KIND_FRAGMENT],
			chk.kinds_seen[wsd_pkg::KIND_FINAL], chk.kinds_seen[wsd_pkg::KIND_PING],
			chk.kinds_seen[wsd_pkg::KIND_PONG], chk.kinds_seen[wsd_pkg::KIND_CLOSE],
			chk.kinds_seen[wsd_pkg::KIND_ERROR]);
		if (chk.errors == 0)
			$display("websocket_frame_deframer_tb: done, clean");
		else
			$display("websocket_frame_deframer_tb: done, errors");
		$finish;
	end

endmodule

/* sim.f */
design/wsd_pkg.sv
design/wsd_parse.sv
design/wsd_out_buf.sv
design/websocket_frame_deframer.sv
test/websocket_frame_deframer_tb.sv
